// ----- design/u8v_pkg.sv -----
`default_nettype none

package u8v_pkg;

   localparam int QUEUE_DEPTH_DEFAULT  = 4;
   localparam int RESULT_DEPTH_DEFAULT = 2;

   localparam logic [20:0] MAX_SCALAR     = 21'h10ffff;
   localparam logic [20:0] SURROGATE_LO   = 21'h00d800;
   localparam logic [20:0] SURROGATE_HI   = 21'h00dfff;
   localparam logic [20:0] MIN_TWO_BYTE   = 21'h000080;
   localparam logic [20:0] MIN_THREE_BYTE = 21'h000800;
   localparam logic [20:0] MIN_FOUR_BYTE  = 21'h010000;

   typedef enum logic [2:0] {
      CLS_ASCII = 3'd0,
      CLS_LEAD2 = 3'd1,
      CLS_LEAD3 = 3'd2,
      CLS_LEAD4 = 3'd3,
      CLS_CONT  = 3'd4,
      CLS_BAD   = 3'd5
   } byte_class_type;

   typedef enum logic [2:0] {
      STATUS_SCALAR   = 3'd0,
      STATUS_BAD_LEAD = 3'd1,
      STATUS_BAD_CONT = 3'd2,
      STATUS_OVERLONG = 3'd3,
      STATUS_RANGE    = 3'd4,
      STATUS_TRUNC    = 3'd5,
      STATUS_DONE     = 3'd6
   } status_type;

   typedef struct packed {
      byte_class_type cls;
      logic [6:0]     bits;
      logic           last;
   } item_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic [2:0]  seq_width;
      status_type  status;
      logic        buffer_done;
      logic        buffer_valid;
   } result_type;

endpackage

`default_nettype wire

// ----- design/u8v_fifo.sv -----
`default_nettype none

module u8v_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rd_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ----- design/u8v_front.sv -----
`default_nettype none

module u8v_front import u8v_pkg::*; (
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_byte_in,
   input  wire logic       req_last_of_buffer,
   output logic            q_push,
   output item_type        q_item,
   input  wire logic       q_full
);

   assign req_full = q_full;
   assign q_push   = req_push;

   // byte class and the payload bits it carries
   always_comb begin
      q_item.last = req_last_of_buffer;
      q_item.cls  = CLS_BAD;
      q_item.bits = '0;
      if (req_byte_in[7] == 1'b0) begin
         q_item.cls  = CLS_ASCII;
         q_item.bits = req_byte_in[6:0];
      end else if (req_byte_in[7:6] == 2'b10) begin
         q_item.cls  = CLS_CONT;
         q_item.bits = {1'b0, req_byte_in[5:0]};
      end else if (req_byte_in inside {[8'hc2:8'hdf]}) begin
         q_item.cls  = CLS_LEAD2;
         q_item.bits = {2'b0, req_byte_in[4:0]};
      end else if (req_byte_in inside {[8'he0:8'hef]}) begin
         q_item.cls  = CLS_LEAD3;
         q_item.bits = {3'b0, req_byte_in[3:0]};
      end else if (req_byte_in inside {[8'hf0:8'hf4]}) begin
         q_item.cls  = CLS_LEAD4;
         q_item.bits = {4'b0, req_byte_in[2:0]};
      end
   end

endmodule

`default_nettype wire

// ----- design/u8v_back.sv -----
`default_nettype none

module u8v_back import u8v_pkg::*; #(
   parameter int RESULT_DEPTH = RESULT_DEPTH_DEFAULT
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire item_type q_item,
   input  wire logic     q_empty,
   output logic          q_pop,
   output result_type    rsp_result,
   output logic          rsp_empty,
   input  wire logic     rsp_pop
);

   logic [1:0]  bytes_left_ff, bytes_left_in;
   logic [2:0]  seq_len_ff, seq_len_in;
   logic [20:0] accum_ff, accum_in;
   logic        error_seen_ff, error_seen_in;

   logic        res_full;
   logic        take;
   logic        has_res;
   result_type  res;
   logic [20:0] acc_next;
   logic [1:0]  left_next;
   logic [20:0] min_scalar;
   logic [$bits(result_type)-1:0] res_bits_out;

   assign take  = !q_empty && !res_full;
   assign q_pop = take;

   assign acc_next  = {accum_ff[14:0], q_item.bits[5:0]};
   assign left_next = bytes_left_ff - 2'd1;

   always_comb begin
      case (seq_len_ff)
         3'd4:    min_scalar = MIN_FOUR_BYTE;
         3'd3:    min_scalar = MIN_THREE_BYTE;
         default: min_scalar = MIN_TWO_BYTE;
      endcase
   end

   always_comb begin
      bytes_left_in  = bytes_left_ff;
      seq_len_in     = seq_len_ff;
      accum_in       = accum_ff;
      error_seen_in  = error_seen_ff;
      has_res        = 1'b0;
      res.code_point = '0;
      res.seq_width  = '0;
      res.status     = STATUS_SCALAR;

      if (error_seen_ff) begin
         if (q_item.last) begin
            has_res    = 1'b1;
            res.status = STATUS_DONE;
         end
      end else if (bytes_left_ff == 2'd0) begin
         case (q_item.cls)
            CLS_ASCII: begin
               has_res        = 1'b1;
               res.code_point = {14'b0, q_item.bits};
               res.seq_width  = 3'd1;
            end
            CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
               if (q_item.cls == CLS_LEAD2) begin
                  seq_len_in    = 3'd2;
                  bytes_left_in = 2'd1;
               end else if (q_item.cls == CLS_LEAD3) begin
                  seq_len_in    = 3'd3;
                  bytes_left_in = 2'd2;
               end else begin
                  seq_len_in    = 3'd4;
                  bytes_left_in = 2'd3;
               end
               accum_in = {14'b0, q_item.bits};
               if (q_item.last) begin
                  has_res    = 1'b1;
                  res.status = STATUS_TRUNC;
               end
            end
            default: begin
               has_res    = 1'b1;
               res.status = STATUS_BAD_LEAD;
            end
         endcase
      end else if (q_item.cls != CLS_CONT) begin
         has_res    = 1'b1;
         res.status = STATUS_BAD_CONT;
      end else begin
         accum_in      = acc_next;
         bytes_left_in = left_next;
         if (left_next == 2'd0) begin
            has_res = 1'b1;
            if (acc_next < min_scalar) begin
               res.status = STATUS_OVERLONG;
            end else if (acc_next > MAX_SCALAR ||
                         (acc_next >= SURROGATE_LO && acc_next <= SURROGATE_HI)) begin
               res.status = STATUS_RANGE;
            end else begin
               res.code_point = acc_next;
               res.seq_width  = seq_len_ff;
               accum_in       = '0;
               seq_len_in     = '0;
            end
         end else if (q_item.last) begin
            has_res    = 1'b1;
            res.status = STATUS_TRUNC;
         end
      end

      // any error ends the sequence and mutes the rest of the buffer
      if (has_res && res.status != STATUS_SCALAR) begin
         error_seen_in = 1'b1;
         bytes_left_in = '0;
      end

      res.buffer_done  = has_res && q_item.last;
      res.buffer_valid = has_res && q_item.last && res.status == STATUS_SCALAR;

      if (has_res && q_item.last) begin
         bytes_left_in = '0;
         seq_len_in    = '0;
         accum_in      = '0;
         error_seen_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= '0;
         seq_len_ff    <= '0;
         accum_ff      <= '0;
         error_seen_ff <= 1'b0;
      end else if (take) begin
         bytes_left_ff <= bytes_left_in;
         seq_len_ff    <= seq_len_in;
         accum_ff      <= accum_in;
         error_seen_ff <= error_seen_in;
      end
   end

   u8v_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (RESULT_DEPTH)
   ) u_result_q (
      .clock   (clock),
      .reset   (reset),
      .push    (take && has_res),
      .wr_data (res),
      .full    (res_full),
      .pop     (rsp_pop),
      .rd_data (res_bits_out),
      .empty   (rsp_empty)
   );

   assign rsp_result = result_type'(res_bits_out);

endmodule

`default_nettype wire

// ----- design/utf8_stream_validator_decoder_core.sv -----
// UTF-8 validator and decoder. Each pushed word is one byte of a buffer,
// with req_last_of_buffer marking the final byte. Every decoded scalar and
// the first error of a buffer appear as one result word; bytes after an
// error give nothing until the last byte, whose result closes the buffer
// with buffer_done set and buffer_valid telling whether the whole buffer
// was well formed. One byte is accepted every cycle while the queues have
// room, and each result passes through the byte queue and then the result
// queue, written by the combinational decode step. The decode state loop
// (bytes still expected, scalar bits gathered so far) updates once per
// byte and sets that rate.
`default_nettype none

module utf8_stream_validator_decoder_core import u8v_pkg::*; #(
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEFAULT,
   parameter int RESULT_DEPTH = RESULT_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_byte_in,
   input  wire logic        req_last_of_buffer,
   output logic             empty,
   input  wire logic        pop,
   output logic      [20:0] rsp_code_point,
   output logic      [2:0]  rsp_seq_width,
   output logic      [2:0]  rsp_status,
   output logic             rsp_buffer_done,
   output logic             rsp_buffer_valid
);

   logic       q_push, q_full, q_empty, q_pop;
   item_type   q_wr_item, q_rd_item;
   logic [$bits(item_type)-1:0] q_rd_bits;
   result_type result;

   u8v_front u_front (
      .req_push           (push),
      .req_full           (full),
      .req_byte_in        (req_byte_in),
      .req_last_of_buffer (req_last_of_buffer),
      .q_push             (q_push),
      .q_item             (q_wr_item),
      .q_full             (q_full)
   );

   u8v_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_byte_q (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_item),
      .full    (q_full),
      .pop     (q_pop),
      .rd_data (q_rd_bits),
      .empty   (q_empty)
   );

   assign q_rd_item = item_type'(q_rd_bits);

   u8v_back #(
      .RESULT_DEPTH (RESULT_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_item     (q_rd_item),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_result (result),
      .rsp_empty  (empty),
      .rsp_pop    (pop)
   );

   assign rsp_code_point   = result.code_point;
   assign rsp_seq_width    = result.seq_width;
   assign rsp_status       = result.status;
   assign rsp_buffer_done  = result.buffer_done;
   assign rsp_buffer_valid = result.buffer_valid;

endmodule

`default_nettype wire

// ----- tb/sv/utf8_stream_validator_decoder_core_tb.sv -----
`default_nettype none

module utf8_stream_validator_decoder_core_tb;
   import u8v_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
      logic       drain_first;
   } byte_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_byte_in = 8'h00;
   logic        req_last_of_buffer = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic [20:0] rsp_code_point;
   logic [2:0]  rsp_seq_width;
   logic [2:0]  rsp_status;
   logic        rsp_buffer_done;
   logic        rsp_buffer_valid;

   byte_word_type pending_bytes[$];
   result_type    expected_words[$];
   logic [7:0]    buffer_build[$];
   int            mismatch_count = 0;

   // decoder state mirror
   logic [1:0]  cont_left = '0;
   logic [2:0]  open_width = '0;
   logic [20:0] scalar_bits = '0;
   logic        buffer_failed = 1'b0;

   // sender burst and receiver stall pattern
   int          burst_left = 0;
   int          gap_left = 0;
   int          recv_mode = 0;
   int          recv_phase_left = 0;
   logic [7:0]  pop_pattern = 8'hff;

   utf8_stream_validator_decoder_core dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_byte_in        (req_byte_in),
      .req_last_of_buffer (req_last_of_buffer),
      .empty              (empty),
      .pop                (pop),
      .rsp_code_point     (rsp_code_point),
      .rsp_seq_width      (rsp_seq_width),
      .rsp_status         (rsp_status),
      .rsp_buffer_done    (rsp_buffer_done),
      .rsp_buffer_valid   (rsp_buffer_valid)
   );

   always #5 clock = ~clock;

   function automatic void queue_result(logic [20:0] cp, logic [2:0] width, status_type st,
                                        logic last);
      result_type r;
      r.code_point   = cp;
      r.seq_width    = width;
      r.status       = st;
      r.buffer_done  = last;
      r.buffer_valid = last && (st == STATUS_SCALAR);
      expected_words.push_back(r);
      if (last) begin
         cont_left     = '0;
         open_width    = '0;
         scalar_bits   = '0;
         buffer_failed = 1'b0;
      end
   endfunction

   function automatic void flag_error(status_type st, logic last);
      buffer_failed = 1'b1;
      cont_left     = '0;
      queue_result('0, '0, st, last);
   endfunction

   function automatic void decode_byte(logic [7:0] b, logic last);
      logic [20:0] lower;
      logic [20:0] cp;
      logic [2:0]  width;
      logic        opened;
      opened = 1'b0;
      if (buffer_failed) begin
         if (last) queue_result('0, '0, STATUS_DONE, 1'b1);
      end else if (cont_left == 2'd0) begin
         if (b <= 8'h7f) begin
            queue_result({13'd0, b}, 3'd1, STATUS_SCALAR, last);
         end else if (b >= 8'hc2 && b <= 8'hdf) begin
            open_width = 3'd2; cont_left = 2'd1; scalar_bits = {16'd0, b[4:0]}; opened = 1'b1;
         end else if (b >= 8'he0 && b <= 8'hef) begin
            open_width = 3'd3; cont_left = 2'd2; scalar_bits = {17'd0, b[3:0]}; opened = 1'b1;
         end else if (b >= 8'hf0 && b <= 8'hf4) begin
            open_width = 3'd4; cont_left = 2'd3; scalar_bits = {18'd0, b[2:0]}; opened = 1'b1;
         end else begin
            flag_error(STATUS_BAD_LEAD, last);
         end
         if (opened && last) flag_error(STATUS_TRUNC, 1'b1);
      end else if (b[7:6] != 2'b10) begin
         flag_error(STATUS_BAD_CONT, last);
      end else begin
         scalar_bits = {scalar_bits[14:0], b[5:0]};
         cont_left   = cont_left - 2'd1;
         if (cont_left == 2'd0) begin
            lower = (open_width >= 3'd4) ? MIN_FOUR_BYTE :
                    (open_width == 3'd3) ? MIN_THREE_BYTE : MIN_TWO_BYTE;
            if (scalar_bits < lower) begin
               flag_error(STATUS_OVERLONG, last);
            end else if (scalar_bits > MAX_SCALAR ||
                         (scalar_bits >= SURROGATE_LO && scalar_bits <= SURROGATE_HI)) begin
               flag_error(STATUS_RANGE, last);
            end else begin
               cp          = scalar_bits;
               width       = open_width;
               scalar_bits = '0;
               open_width  = '0;
               queue_result(cp, width, STATUS_SCALAR, last);
            end
         end else if (last) begin
            flag_error(STATUS_TRUNC, 1'b1);
         end
      end
   endfunction

   function automatic void encode_scalar(logic [20:0] cp, int width);
      case (width)
         1: buffer_build.push_back({1'b0, cp[6:0]});
         2: begin
            buffer_build.push_back({3'b110, cp[10:6]});
            buffer_build.push_back({2'b10, cp[5:0]});
         end
         3: begin
            buffer_build.push_back({4'b1110, cp[15:12]});
            buffer_build.push_back({2'b10, cp[11:6]});
            buffer_build.push_back({2'b10, cp[5:0]});
         end
         default: begin
            buffer_build.push_back({5'b11110, cp[20:18]});
            buffer_build.push_back({2'b10, cp[17:12]});
            buffer_build.push_back({2'b10, cp[11:6]});
            buffer_build.push_back({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   function automatic int flush_buffer(logic drain);
      byte_word_type w;
      int n;
      n = buffer_build.size();
      for (int i = 0; i < n; i++) begin
         w.value       = buffer_build[i];
         w.last        = (i == n - 1);
         w.drain_first = drain && (i == 0);
         pending_bytes.push_back(w);
      end
      buffer_build.delete();
      return n;
   endfunction

   function automatic logic [20:0] valid_scalar(int width);
      logic [20:0] cp;
      case (width)
         1: cp = 21'($urandom_range(0, 'h7f));
         2: cp = 21'($urandom_range('h80, 'h7ff));
         3: begin
            cp = 21'($urandom_range('h800, 'hffff));
            if (cp >= SURROGATE_LO && cp <= SURROGATE_HI) cp = cp ^ 21'h002000;
         end
         default: cp = 21'($urandom_range('h10000, 'h10ffff));
      endcase
      return cp;
   endfunction

   function automatic int add_random_buffer(logic drain);
      int n_tokens;
      int kind;
      int width;
      int start;
      logic [7:0] bad;
      n_tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 6);
      for (int t = 0; t < n_tokens; t++) begin
         kind  = $urandom_range(0, 19);
         width = $urandom_range(2, 4);
         start = buffer_build.size();
         if (kind <= 12) begin
            width = $urandom_range(1, 4);
            encode_scalar(valid_scalar(width), width);
         end else if (kind == 13) begin
            buffer_build.push_back(8'($urandom_range(0, 255)));
         end else if (kind == 14) begin
            case (width)
               2: encode_scalar(21'($urandom_range(0, 'h7f)), 2);
               3: encode_scalar(21'($urandom_range(0, 'h7ff)), 3);
               default: encode_scalar(21'($urandom_range(0, 'hffff)), 4);
            endcase
         end else if (kind == 15) begin
            encode_scalar(21'($urandom_range('hd800, 'hdfff)), 3);
         end else if (kind == 16) begin
            encode_scalar(21'($urandom_range('h110000, 'h1fffff)), 4);
         end else if (kind == 17) begin
            encode_scalar(valid_scalar(width), width);
            bad = 8'($urandom_range(0, 255));
            if (bad[7:6] == 2'b10) bad[6] = 1'b1;
            buffer_build[start + $urandom_range(1, width - 1)] = bad;
         end else if (kind == 18) begin
            encode_scalar(valid_scalar(width), width);
            repeat ($urandom_range(1, width - 1)) void'(buffer_build.pop_back());
         end else begin
            buffer_build.push_back(8'($urandom_range('h80, 'hbf)));
         end
      end
      return flush_buffer(drain);
   endfunction

   // sender: bursts of words with random gaps
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) decode_byte(req_byte_in, req_last_of_buffer);
         if (!(push && full)) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               push     <= 1'b0;
            end else if (pending_bytes.size() == 0 ||
                         (pending_bytes[0].drain_first && expected_words.size() != 0)) begin
               push <= 1'b0;
            end else begin
               req_byte_in        <= pending_bytes[0].value;
               req_last_of_buffer <= pending_bytes[0].last;
               void'(pending_bytes.pop_front());
               push <= 1'b1;
               if (burst_left <= 1) begin
                  if ($urandom_range(0, 9) == 0) begin
                     burst_left <= $urandom_range(50, 150);
                     gap_left   <= 0;
                  end else begin
                     burst_left <= $urandom_range(1, 24);
                     gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                  end
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
   end

   // receiver: check each popped word, stall on a changing pattern
   always @(posedge clock) begin : receiver
      result_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_words.size() == 0) begin
               $error("unexpected word: code_point %0h status %0d", rsp_code_point, rsp_status);
               mismatch_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_code_point !== want.code_point) begin
                  $error("code_point: expected %0h, actual %0h", want.code_point, rsp_code_point);
                  mismatch_count++;
               end
               if (rsp_seq_width !== want.seq_width) begin
                  $error("seq_width: expected %0d, actual %0d", want.seq_width, rsp_seq_width);
                  mismatch_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_buffer_done !== want.buffer_done) begin
                  $error("buffer_done: expected %0b, actual %0b", want.buffer_done,
                         rsp_buffer_done);
                  mismatch_count++;
               end
               if (rsp_buffer_valid !== want.buffer_valid) begin
                  $error("buffer_valid: expected %0b, actual %0b", want.buffer_valid,
                         rsp_buffer_valid);
                  mismatch_count++;
               end
            end
         end
         if (recv_phase_left == 0) begin
            recv_mode       <= $urandom_range(0, 3);
            recv_phase_left <= $urandom_range(64, 256);
            pop_pattern     <= 8'($urandom_range(1, 255));
         end else begin
            recv_phase_left <= recv_phase_left - 1;
            pop_pattern     <= {pop_pattern[6:0], pop_pattern[7]};
         end
         case (recv_mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 3) != 0);
            2: pop <= ($urandom_range(0, 3) == 0);
            default: pop <= pop_pattern[7];
         endcase
      end
   end

   initial begin
      int random_bytes;
      int next_drain_at;
      random_bytes  = 0;
      next_drain_at = 0;

      // ascii extremes
      buffer_build = '{8'h00, 8'h7f};
      void'(flush_buffer(1'b0));
      // largest scalar
      buffer_build = '{8'hf4, 8'h8f, 8'hbf, 8'hbf};
      void'(flush_buffer(1'b0));
      // bad lead, then words discarded up to the end of the buffer
      buffer_build = '{8'hff, 8'h41, 8'h42};
      void'(flush_buffer(1'b0));
      // bad continuation on the final word
      buffer_build = '{8'hc2, 8'h41};
      void'(flush_buffer(1'b0));
      // sequence still open at the end
      buffer_build = '{8'he1, 8'h80};
      void'(flush_buffer(1'b0));
      // surrogate closing the buffer
      buffer_build = '{8'hed, 8'ha0, 8'h80};
      void'(flush_buffer(1'b0));
      // bad lead as the only word
      buffer_build = '{8'hc1};
      void'(flush_buffer(1'b0));
      // overlong four-word form
      buffer_build = '{8'hf0, 8'h8f, 8'hbf, 8'hbf};
      void'(flush_buffer(1'b0));
      // smallest two-word scalar
      buffer_build = '{8'hc2, 8'h80};
      void'(flush_buffer(1'b0));

      while (random_bytes < 1700) begin
         if (random_bytes >= next_drain_at) begin
            random_bytes += add_random_buffer(1'b1);
            next_drain_at += 400;
         end else begin
            random_bytes += add_random_buffer(1'b0);
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || push) @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire
